/* rtl/core/jsu_pkg.sv */
// Shared types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_EARLY_END  = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd2;
    localparam logic [2:0] ERR_RANGE      = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd4;
    localparam logic [2:0] ERR_CTRL_ESC   = 3'd5;
    localparam logic [2:0] ERR_RAW_CTRL   = 3'd6;

    // Register map (word index taken from paddr[2])
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    // Characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [15:0] CODE_MIN = 16'h0020;
    localparam logic [15:0] CODE_MAX = 16'h007E;

    // One result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_value;
        logic [15:0] length;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    // Output buffer occupancy
    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_obuf_status;

    // Hex digit decode: bit 4 marks a valid digit, bits 3:0 its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b1, 4'(c - 8'h41 + 8'd10)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b1, 4'(c - 8'h61 + 8'd10)};
            end
            return r;
        end
    endfunction

endpackage

/* rtl/core/jsu_decode.sv */
// Input word register and per-byte string decoder state machine.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_eod,
    input  logic [15:0] i_capacity,
    input  logic        i_space,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eod;
    t_phase      r_phase, n_phase;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_emit_cnt, n_emit_cnt;

    logic        w_fire;
    logic        w_ws, w_quote, w_bslash, w_simple_esc, w_ctrl_esc, w_ctrl;
    logic [4:0]  w_hd;
    logic [15:0] w_hex_next;
    logic        w_hex_range_bad;
    logic        w_can_emit;

    // Process the held word when the output side has room
    assign w_fire     = r_in_valid && i_space;
    assign o_in_ready = !r_in_valid || w_fire;

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_eod  <= i_in_eod;
        end
    end

    // Byte classes
    assign w_ws         = (r_in_byte == CH_SPACE) ||
                          (r_in_byte >= CH_TAB && r_in_byte <= CH_CR);
    assign w_quote      = (r_in_byte == CH_QUOTE);
    assign w_bslash     = (r_in_byte == CH_BSLASH);
    assign w_simple_esc = w_quote || w_bslash || (r_in_byte == CH_SLASH);
    assign w_ctrl_esc   = (r_in_byte == CH_LOW_B) || (r_in_byte == CH_LOW_F) ||
                          (r_in_byte == CH_LOW_N) || (r_in_byte == CH_LOW_R) ||
                          (r_in_byte == CH_LOW_T);
    assign w_ctrl       = (r_in_byte < CH_SPACE) || (r_in_byte == CH_DEL);
    assign w_hd         = hex_digit(r_in_byte);
    assign w_hex_next   = {r_hex[11:0], w_hd[3:0]};
    assign w_hex_range_bad = (w_hex_next < CODE_MIN) || (w_hex_next > CODE_MAX);
    assign w_can_emit   = ({1'b0, r_emit_cnt} + 17'd1) < {1'b0, i_capacity};

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            if (r_in_eod) begin
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (!w_ws && w_quote) n_phase = PH_STR;
                    end
                    PH_STR: begin
                        if (w_quote) n_phase = PH_IDLE;
                        else if (w_bslash) n_phase = PH_ESC;
                        else if (w_ctrl) n_phase = PH_IDLE;
                    end
                    PH_ESC: begin
                        if (w_simple_esc) n_phase = PH_STR;
                        else if (r_in_byte == CH_LOW_U && !w_ctrl_esc) n_phase = PH_HEX;
                        else n_phase = PH_IDLE;
                    end
                    PH_HEX: begin
                        if (!w_hd[4]) n_phase = PH_IDLE;
                        else if (r_hex_cnt == 2'd3) begin
                            n_phase = w_hex_range_bad ? PH_IDLE : PH_STR;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Counters and result
    always_comb begin
        n_hex       = r_hex;
        n_hex_cnt   = r_hex_cnt;
        n_emit_cnt  = r_emit_cnt;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (w_fire) begin
            if (r_in_eod) begin
                o_res_valid = 1'b1;
                o_res.kind = KIND_ERR; o_res.error_code = ERR_EARLY_END; o_res.last = 1'b1;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (w_quote) begin
                            n_emit_cnt = '0;
                        end else if (!w_ws) begin
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERR; o_res.error_code = ERR_NO_QUOTE;
                            o_res.last = 1'b1;
                        end
                    end
                    PH_STR: begin
                        if (w_quote) begin
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_DONE; o_res.length = r_emit_cnt;
                            o_res.last = 1'b1;
                        end else if (w_bslash) begin
                            n_emit_cnt = r_emit_cnt;
                        end else if (w_ctrl) begin
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERR; o_res.error_code = ERR_RAW_CTRL;
                            o_res.last = 1'b1;
                        end else if (w_can_emit) begin
                            n_emit_cnt = r_emit_cnt + 16'd1;
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_CHAR; o_res.char_value = r_in_byte;
                        end
                    end
                    PH_ESC: begin
                        if (w_simple_esc) begin
                            if (w_can_emit) begin
                                n_emit_cnt = r_emit_cnt + 16'd1;
                                o_res_valid = 1'b1;
                                o_res.kind = KIND_CHAR; o_res.char_value = r_in_byte;
                            end
                        end else if (w_ctrl_esc) begin
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERR; o_res.error_code = ERR_CTRL_ESC;
                            o_res.last = 1'b1;
                        end else if (r_in_byte == CH_LOW_U) begin
                            n_hex     = '0;
                            n_hex_cnt = '0;
                        end else begin
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERR; o_res.error_code = ERR_BAD_ESC;
                            o_res.last = 1'b1;
                        end
                    end
                    PH_HEX: begin
                        if (!w_hd[4]) begin
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERR; o_res.error_code = ERR_BAD_HEX;
                            o_res.last = 1'b1;
                        end else if (r_hex_cnt != 2'd3) begin
                            n_hex     = w_hex_next;
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else if (w_hex_range_bad) begin
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERR; o_res.error_code = ERR_RANGE;
                            o_res.last = 1'b1;
                        end else begin
                            n_hex     = '0;
                            n_hex_cnt = '0;
                            if (w_can_emit) begin
                                n_emit_cnt = r_emit_cnt + 16'd1;
                                o_res_valid = 1'b1;
                                o_res.kind = KIND_CHAR; o_res.char_value = w_hex_next[7:0];
                            end
                        end
                    end
                    default: begin
                        o_res_valid = 1'b0;
                    end
                endcase
            end
            // Any completion or error clears the counters
            if (o_res_valid && o_res.last) begin
                n_hex      = '0;
                n_hex_cnt  = '0;
                n_emit_cnt = '0;
            end
        end
    end

    // Advance decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hex      <= '0;
            r_hex_cnt  <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hex      <= n_hex;
            r_hex_cnt  <= n_hex_cnt;
            r_emit_cnt <= n_emit_cnt;
        end
    end

endmodule

/* rtl/core/jsu_obuf.sv */
// Result register with a skid stage toward the output stream.
module jsu_obuf
    import jsu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_result      i_data,
    output logic         o_space,
    output t_obuf_status o_status,
    output logic         o_valid,
    input  logic         i_ready,
    output t_result      o_data
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    w_pop, w_out_free;

    assign w_pop      = r_out_valid && i_ready;
    assign w_out_free = !r_out_valid || w_pop;
    assign o_space    = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign o_status   = '{out_valid: r_out_valid, skid_valid: r_skid_valid};

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Move words: skid drains into the output register first
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_push) r_skid <= i_data;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

/* rtl/core/json_string_unescaper.sv */
// A word accepted on s_axis is held in the input register, decoded, and its result is registered
// in the result register, or first in the skid stage behind it, before it shows on m_axis.
// Throughput: one input word per cycle; the input register stalls only while the
// result register and its skid stage are both full.
// Reset: synchronous, active low; decoder returns to idle with counters cleared,
// capacity returns to 256, no result pending.
// Top level: APB register, byte decoder and result buffer.
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tuser,   // [0] end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] char_value, [23:8] length, [26:24] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]  r_capacity;
    logic         w_space, w_res_valid;
    t_result      w_res, w_out;
    t_obuf_status w_status;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {16'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata[15:0];
        end
    end

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_in_eod    (s_axis_tuser),
        .i_capacity  (r_capacity),
        .i_space     (w_space),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    jsu_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_valid),
        .i_data   (w_res),
        .o_space  (w_space),
        .o_status (w_status),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (w_out)
    );

    // Pack the result word
    assign m_axis_tdata = {5'd0, w_out.error_code, w_out.length, w_out.char_value};
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.last;

`ifndef NO_ASSERTIONS
    // Skid stage only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.skid_valid |-> w_status.out_valid)
        else $error("skid word without output word");

    // Characters never close a string; completions and errors always do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_CHAR)))
        else $error("tlast does not match kind");

    // Reported length is zero or stays below capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |->
        (m_axis_tdata[23:8] == 16'd0 || m_axis_tdata[23:8] < r_capacity))
        else $error("completion length exceeds capacity");
`endif

endmodule
